/* sv/svpwm_pkg.sv */
package svpwm_pkg;

    // Working width of the signed datapath; holds every intermediate duty
    localparam int WorkW = 22;

    // Alpha gain 222/128, applied as multiply then truncating shift
    localparam logic signed [23:0] ALPHA_GAIN  = 24'sd222;
    localparam int                 ALPHA_SHIFT = 7;

    localparam logic [15:0] PERIOD_RESET = 16'd1799;

    // Sector codes
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;
    localparam logic [2:0] SECTOR_6 = 3'd6;

    typedef struct packed {
        logic signed [15:0] alpha_voltage;
        logic signed [15:0] beta_voltage;
    } vec_t;

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic [2:0]  sector;
        logic        clipped;
    } duty_t;

    // Halve, truncating toward zero
    function automatic logic signed [WorkW-1:0] half_trunc(
        input logic signed [WorkW-1:0] v
    );
        logic signed [WorkW-1:0] t;
        t = v + $signed({{(WorkW-1){1'b0}}, v[WorkW-1]});
        return t >>> 1;
    endfunction

endpackage

/* sv/space_vector_pwm_duty.sv */
// Channel | Dir | Handshake            | Word
// vec     | in  | vec_valid/vec_ready  | svpwm_pkg::vec_t (alpha, beta)
// duty    | out | duty_valid/duty_ready| svpwm_pkg::duty_t (duties, sector, clip)
// cfg     | in  | cfg_valid/cfg_ready  | 16-bit pwm_period, always ready
//
// Two register stages: X/Y/Z and sector, then duties and clamp.
// A word passes the stage 1 register, then the output register; one word per cycle while duty_ready stays high.
// Reset clears both stage valids and loads the period with 1799.
// A stalled output holds its word; the first stage still fills behind it.
module space_vector_pwm_duty (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vec_valid,
    output logic              vec_ready,
    input  svpwm_pkg::vec_t   vec,
    output logic              duty_valid,
    input  logic              duty_ready,
    output svpwm_pkg::duty_t  duty,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data
);

    localparam int W = svpwm_pkg::WorkW;

    logic [15:0] period_reg;

    logic                s1_valid_reg;
    logic signed [W-1:0] x_reg, y_reg, z_reg;
    logic [2:0]          sector_reg;

    logic             out_valid_reg;
    svpwm_pkg::duty_t out_reg;

    logic out_free;
    logic s1_move;
    logic vec_take;

    // Handshake control
    assign out_free   = !out_valid_reg || duty_ready;
    assign s1_move    = s1_valid_reg && out_free;
    assign vec_ready  = !s1_valid_reg || out_free;
    assign vec_take   = vec_valid && vec_ready;
    assign cfg_ready  = 1'b1;
    assign duty_valid = out_valid_reg;
    assign duty       = out_reg;

    // Stage 1: form X, Y, Z and pick the sector
    logic signed [23:0]  prod;
    logic signed [23:0]  prod_adj;
    logic signed [23:0]  ua_full;
    logic signed [W-1:0] ua, ub, sum_y, dif_z;
    logic signed [W-1:0] x_next, y_next, z_next;
    logic [2:0]          sector_next;
    logic                x_pos;

    always_comb
    begin
        prod     = $signed({{8{vec.alpha_voltage[15]}}, vec.alpha_voltage})
                   * svpwm_pkg::ALPHA_GAIN;
        prod_adj = prod + $signed({17'b0, {svpwm_pkg::ALPHA_SHIFT{prod[23]}}});
        ua_full  = prod_adj >>> svpwm_pkg::ALPHA_SHIFT;
        ua       = $signed(ua_full[W-1:0]);
        ub       = -$signed({{(W-16){vec.beta_voltage[15]}}, vec.beta_voltage});
        sum_y    = ua + ub;
        dif_z    = ub - ua;
        x_next   = ub;
        y_next   = svpwm_pkg::half_trunc(sum_y);
        z_next   = svpwm_pkg::half_trunc(dif_z);
        x_pos    = !x_next[W-1] && (x_next != '0);
        if (y_next[W-1])
        begin
            if (z_next[W-1])
            begin
                sector_next = svpwm_pkg::SECTOR_5;
            end
            else
            begin
                sector_next = x_pos ? svpwm_pkg::SECTOR_3 : svpwm_pkg::SECTOR_4;
            end
        end
        else
        begin
            if (z_next[W-1])
            begin
                sector_next = x_pos ? svpwm_pkg::SECTOR_1 : svpwm_pkg::SECTOR_6;
            end
            else
            begin
                sector_next = svpwm_pkg::SECTOR_2;
            end
        end
    end

    // Stage 2: place duties around the period and clamp
    logic signed [W-1:0] p_full, p_half, p_quarter;
    logic signed [W-1:0] op_u, op_v;
    logic signed [W-1:0] a_raw, b_raw, c_raw;
    logic [15:0]         a_clamp, b_clamp, c_clamp;
    logic                a_clip, b_clip, c_clip;
    svpwm_pkg::duty_t    out_next;

    function automatic logic [16:0] clamp_duty(
        input logic signed [W-1:0] v,
        input logic signed [W-1:0] top
    );
        // bit 16 flags a clamp, bits 15:0 carry the value
        logic [16:0] r;
        if (v[W-1])
        begin
            r = {1'b1, 16'd0};
        end
        else if (v > top)
        begin
            r = {1'b1, top[15:0]};
        end
        else
        begin
            r = {1'b0, v[15:0]};
        end
        return r;
    endfunction

    always_comb
    begin
        p_full    = $signed({{(W-16){1'b0}}, period_reg});
        p_quarter = $signed({{(W-14){1'b0}}, period_reg[15:2]});
        p_half    = $signed({{(W-15){1'b0}}, period_reg[15:1]});
        case (sector_reg)
            svpwm_pkg::SECTOR_1, svpwm_pkg::SECTOR_4:
            begin
                op_u = x_reg;
                op_v = z_reg;
            end
            svpwm_pkg::SECTOR_2, svpwm_pkg::SECTOR_5:
            begin
                op_u = y_reg;
                op_v = z_reg;
            end
            default:
            begin
                op_u = y_reg;
                op_v = x_reg;
            end
        endcase
        a_raw = p_quarter + svpwm_pkg::half_trunc(p_half + op_u - op_v);
        case (sector_reg)
            svpwm_pkg::SECTOR_1, svpwm_pkg::SECTOR_4:
            begin
                c_raw = a_raw + z_reg;
                b_raw = c_raw - x_reg;
            end
            svpwm_pkg::SECTOR_2, svpwm_pkg::SECTOR_5:
            begin
                c_raw = a_raw + z_reg;
                b_raw = a_raw - y_reg;
            end
            default:
            begin
                b_raw = a_raw - y_reg;
                c_raw = b_raw + x_reg;
            end
        endcase
        {a_clip, a_clamp} = clamp_duty(a_raw, p_full);
        {b_clip, b_clamp} = clamp_duty(b_raw, p_full);
        {c_clip, c_clamp} = clamp_duty(c_raw, p_full);
        out_next.duty_a  = a_clamp;
        out_next.duty_b  = b_clamp;
        out_next.duty_c  = c_clamp;
        out_next.sector  = sector_reg;
        out_next.clipped = a_clip | b_clip | c_clip;
    end

    // Control registers: period and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= svpwm_pkg::PERIOD_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                period_reg <= cfg_data;
            end
            if (vec_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (duty_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (vec_take)
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            z_reg      <= z_next;
            sector_reg <= sector_next;
        end
        if (s1_move)
        begin
            out_reg <= out_next;
        end
    end

endmodule
